>>> rtl/core/tiad_pkg.sv
// shared types, widths and the arctangent step table for the tilt angle core
// no dependencies; used by tiad_cordic_stage and tilt_angle_atan2_degrees_core

package tiad_pkg;

   localparam int CORDIC_STAGES  = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int NUM_STAGES     = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                                   CORDIC_STAGES : ATAN_TABLE_LEN;

   localparam int SAMPLE_W  = 16;
   localparam int PRESCALE_SHIFT = 8;
   localparam int XY_W      = 28;
   localparam int ACC_W     = 26;
   localparam int FRAC_W    = 16;
   localparam int DEG_W     = ACC_W - FRAC_W;
   localparam int ANGLE_W   = 9;
   localparam int SHIFT_W   = 5;

   localparam logic signed [ACC_W-1:0] BASE_POS = ACC_W'(180 * 65536);
   localparam logic signed [ACC_W-1:0] BASE_NEG = -ACC_W'(180 * 65536);
   localparam logic signed [DEG_W-1:0] DEG_MIN  = -DEG_W'(179);
   localparam logic signed [DEG_W-1:0] DEG_MAX  = DEG_W'(180);

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero;
   } cordic_data_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         0:       val = ACC_W'(2949120);
         1:       val = ACC_W'(1740967);
         2:       val = ACC_W'(919879);
         3:       val = ACC_W'(466945);
         4:       val = ACC_W'(234379);
         5:       val = ACC_W'(117304);
         6:       val = ACC_W'(58666);
         7:       val = ACC_W'(29335);
         8:       val = ACC_W'(14668);
         9:       val = ACC_W'(7334);
         10:      val = ACC_W'(3667);
         11:      val = ACC_W'(1833);
         12:      val = ACC_W'(917);
         13:      val = ACC_W'(458);
         14:      val = ACC_W'(229);
         15:      val = ACC_W'(115);
         16:      val = ACC_W'(57);
         17:      val = ACC_W'(29);
         18:      val = ACC_W'(14);
         19:      val = ACC_W'(7);
         20:      val = ACC_W'(4);
         21:      val = ACC_W'(2);
         22:      val = ACC_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/core/tiad_cordic_stage.sv
// one registered vectoring cordic iteration with its own valid/ready slot
// depends on tiad_pkg for the data struct and widths

module tiad_cordic_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tiad_pkg::SHIFT_W-1:0]          shift_amt,
   input  logic signed [tiad_pkg::ACC_W-1:0]     atan_inc,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  tiad_pkg::cordic_data_type             in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output tiad_pkg::cordic_data_type             out_data
);

   logic                        valid_ff;
   tiad_pkg::cordic_data_type   data_ff;
   tiad_pkg::cordic_data_type   data_in;
   logic signed [tiad_pkg::XY_W-1:0] xs;
   logic signed [tiad_pkg::XY_W-1:0] ys;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      xs      = in_data.x >>> shift_amt;
      ys      = in_data.y >>> shift_amt;
      data_in = in_data;
      if (!in_data.y[tiad_pkg::XY_W-1]) begin
         data_in.x   = in_data.x + ys;
         data_in.y   = in_data.y - xs;
         data_in.acc = in_data.acc + atan_inc;
      end else begin
         data_in.x   = in_data.x - ys;
         data_in.y   = in_data.y + xs;
         data_in.acc = in_data.acc - atan_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/tilt_angle_atan2_degrees_core.sv
// top level: tilt angle atan2(z, -y) in whole degrees through a pipelined cordic
// depends on tiad_pkg and tiad_cordic_stage
//
// usage
//   req channel: one item is a signed y and z accelerometer sample, taken when
//   req_valid and req_ready are both high.
//   rsp channel: one item per sample, rsp_angle_deg in -179..180, truncated
//   toward zero, in the order the samples came in.
//   pipeline: one fold stage, one stage per cordic iteration, one truncate and
//   clamp stage.
//   throughput: one item per cycle; every stage holds its own valid bit, so a
//   new sample can enter each cycle as long as the pipeline moves.
//   stalls: each stage keeps its item while the stage after it is full and
//   not moving; empty stages still fill, so req_ready stays high until every
//   stage holds an item and rsp_ready is low.
//   reset: synchronous, clears all valid bits; no item is lost or repeated
//   across a stall, and there is no configuration or kept state.

module tilt_angle_atan2_degrees_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tiad_pkg::SAMPLE_W-1:0]  req_accel_y,
   input  logic signed [tiad_pkg::SAMPLE_W-1:0]  req_accel_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tiad_pkg::ANGLE_W-1:0]   rsp_angle_deg
);

   localparam int N = tiad_pkg::NUM_STAGES;

   logic                      stage_valid [0:N];
   logic                      stage_ready [0:N];
   tiad_pkg::cordic_data_type stage_data  [0:N];

   // fold stage
   logic                        prep_valid_ff;
   tiad_pkg::cordic_data_type   prep_ff;
   tiad_pkg::cordic_data_type   prep_in;
   logic signed [tiad_pkg::XY_W-1:0] xv;
   logic signed [tiad_pkg::XY_W-1:0] yv;

   always_comb begin
      xv = -(tiad_pkg::XY_W'(req_accel_y) <<< tiad_pkg::PRESCALE_SHIFT);
      yv = tiad_pkg::XY_W'(req_accel_z) <<< tiad_pkg::PRESCALE_SHIFT;
      prep_in.zero = (req_accel_y == '0) && (req_accel_z == '0);
      if (xv[tiad_pkg::XY_W-1]) begin
         prep_in.x   = -xv;
         prep_in.y   = -yv;
         prep_in.acc = yv[tiad_pkg::XY_W-1] ? tiad_pkg::BASE_NEG : tiad_pkg::BASE_POS;
      end else begin
         prep_in.x   = xv;
         prep_in.y   = yv;
         prep_in.acc = '0;
      end
   end

   assign req_ready = !prep_valid_ff || stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_valid[0] = prep_valid_ff;
   assign stage_data[0]  = prep_ff;

   // cordic iterations
   for (genvar k = 0; k < N; k++) begin : g_stage
      tiad_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (tiad_pkg::SHIFT_W'(k)),
         .atan_inc  (tiad_pkg::atan_step(k)),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // truncate toward zero and clamp
   logic                                     out_valid_ff;
   logic signed [tiad_pkg::ANGLE_W-1:0]      angle_ff;
   logic signed [tiad_pkg::ANGLE_W-1:0]      angle_in;
   logic signed [tiad_pkg::DEG_W-1:0]        deg_floor;
   logic signed [tiad_pkg::DEG_W-1:0]        deg_trunc;
   logic                                     frac_nz;

   always_comb begin
      deg_floor = stage_data[N].acc[tiad_pkg::ACC_W-1:tiad_pkg::FRAC_W];
      frac_nz   = |stage_data[N].acc[tiad_pkg::FRAC_W-1:0];
      deg_trunc = deg_floor +
                  tiad_pkg::DEG_W'(stage_data[N].acc[tiad_pkg::ACC_W-1] && frac_nz);
      if (stage_data[N].zero) begin
         angle_in = '0;
      end else if (deg_trunc < tiad_pkg::DEG_MIN) begin
         angle_in = tiad_pkg::DEG_MIN[tiad_pkg::ANGLE_W-1:0];
      end else if (deg_trunc > tiad_pkg::DEG_MAX) begin
         angle_in = tiad_pkg::DEG_MAX[tiad_pkg::ANGLE_W-1:0];
      end else begin
         angle_in = deg_trunc[tiad_pkg::ANGLE_W-1:0];
      end
   end

   assign stage_ready[N] = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_ready[N]) begin
         out_valid_ff <= stage_valid[N];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid[N] && stage_ready[N]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_angle_deg = angle_ff;

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_deg >= -9'sd179) && (rsp_angle_deg <= 9'sd180))
      else $error("angle out of range");

   a_fold_right_half : assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff |-> !prep_ff.x[tiad_pkg::XY_W-1])
      else $error("folded x is negative");

   a_zero_sample : assert property (@(posedge clock) disable iff (reset)
      (prep_valid_ff && prep_ff.zero) |-> (prep_ff.x == '0) && (prep_ff.y == '0))
      else $error("zero flag on nonzero vector");

   a_fill_when_empty : assert property (@(posedge clock) disable iff (reset)
      !prep_valid_ff |-> req_ready)
      else $error("input blocked with empty fold stage");

endmodule
